@@ rtl/wsts_pkg.sv @@
// ============================================================================
// wsts_pkg
// Shared constants, mode codes and control types of the work-stealing task
// scheduler.
// ============================================================================
package wsts_pkg;

    // Sizing of the scheduler.
    localparam int THREADS     = 16;
    localparam int QUEUE_DEPTH = 256;
    localparam int TASKS       = 1024;

    // Task id that means "no task".
    localparam int NO_TASK = 0;

    // Fixed field widths of the channels.
    localparam int MODE_W = 4;
    localparam int THR_W  = 4;
    localparam int TASK_W = 10;
    localparam int CNT_W  = 8;
    localparam int CFG_W  = 5;

    // Derived widths.
    localparam int QW       = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int PW       = $clog2(QUEUE_DEPTH);
    localparam int FW       = $clog2(QUEUE_DEPTH + 1);
    localparam int SW       = $clog2(THREADS + 1);
    localparam int TIDX_W   = $clog2(TASKS);
    localparam int STORE_AW = QW + PW;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_SET_COUNT = 4'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_STEAL     = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ACT_KEEP  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_ACT_PUSH  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_ACT_ONE   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_GET_READY = 4'd9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;
        logic clr_step;
        logic cnt_rd;
        logic act;
        logic scan;
        logic finish;
    } wsts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic req_valid;
        logic is_steal;
        logic scan_stop;
        logic out_free;
    } wsts_status_t;

endpackage

@@ rtl/wsts_if.sv @@
// ============================================================================
// wsts_if
// Valid/ready channels of the scheduler: the request and the response.
// ============================================================================
interface wsts_req_if;
    import wsts_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [THR_W-1:0]  thread;
    logic [TASK_W-1:0] task_req;
    logic [CNT_W-1:0]  count;
    logic [TASK_W-1:0] current_task;

    modport source (output valid, mode, thread, task_req, count, current_task,
                    input ready);
    modport sink   (input valid, mode, thread, task_req, count, current_task,
                    output ready);
endinterface

interface wsts_rsp_if;
    import wsts_pkg::*;

    logic              valid;
    logic              ready;
    logic [TASK_W-1:0] task_out;
    logic              none_found;
    logic              overflow;

    modport source (output valid, task_out, none_found, overflow, input ready);
    modport sink   (input valid, task_out, none_found, overflow, output ready);
endinterface

@@ rtl/wsts_ram.sv @@
// ============================================================================
// wsts_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds when no read is issued.
// ============================================================================
module wsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/wsts_ctrl.sv @@
// ============================================================================
// wsts_ctrl
// Controller state machine: clearing pass, item intake, count access,
// queue operation, steal scan and result hand-off.
// ============================================================================
module wsts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wsts_pkg::wsts_status_t st,
    output wsts_pkg::wsts_cmd_t    cmd
);
    import wsts_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CNT   = 3'd2;
    localparam logic [2:0] S_ACT   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (st.req_valid)
                begin
                    state_next = S_CNT;
                end
            end
            S_CNT:
            begin
                cmd.cnt_rd = 1'b1;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                cmd.act    = 1'b1;
                state_next = st.is_steal ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_stop)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = st.out_free;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the count clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // An accepted item always goes on to the count access.
    a_accept_to_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && st.req_valid) |=> (state_reg == S_CNT))
        else $error("accepted item did not move to count access");

    // A steal scan that stops goes straight to the hand-off.
    a_scan_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && st.scan_stop) |=> (state_reg == S_DONE))
        else $error("stopped scan did not move to hand-off");

    // A result is only handed off when the output register can take it.
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> st.out_free)
        else $error("result handed off into a busy output register");
`endif
endmodule

@@ rtl/wsts_dp.sv @@
// ============================================================================
// wsts_dp
// Datapath: item register, queue pointers, task store, activation count
// memory, steal scan counter and output register.
// ============================================================================
module wsts_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [wsts_pkg::CFG_W-1:0]   cfg_wdata,
    input  wsts_pkg::wsts_cmd_t          cmd,
    output wsts_pkg::wsts_status_t       st,
    wsts_req_if.sink                     req,
    wsts_rsp_if.source                   rsp
);
    import wsts_pkg::*;

    // Configuration and item registers.
    logic [CFG_W-1:0]  active_threads_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [TASK_W-1:0] task_reg;
    logic [CNT_W-1:0]  cnt_in_reg;
    logic [TASK_W-1:0] cur_reg;

    // Queue pointers.
    logic [PW-1:0] head_reg [THREADS];
    logic [PW-1:0] tail_reg [THREADS];
    logic [FW-1:0] fill_reg [THREADS];

    logic [TIDX_W-1:0] clr_idx_reg;
    logic [SW-1:0]     scan_idx_reg;

    // Result staging and output register.
    logic [TASK_W-1:0] res_reg;
    logic              src_reg;
    logic              ovf_reg;
    logic              out_valid_reg;
    logic [TASK_W-1:0] task_out_reg;
    logic              none_found_reg;
    logic              overflow_reg;

    // Memory ports.
    logic              cnt_we;
    logic [TIDX_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_rdata;
    logic                st_we;
    logic [STORE_AW-1:0] st_waddr;
    logic                st_re;
    logic [STORE_AW-1:0] st_raddr;
    logic [TASK_W-1:0]   st_rdata;

    // Decode of the item under work.
    logic          thr_ok;
    logic [QW-1:0] q;
    logic          task_nz;
    logic          task_ok;
    logic          dec;
    logic          fired;
    logic          cur_nz;
    logic          q_full;
    logic          q_empty;
    logic [PW-1:0] head_dec;
    logic          push_req;
    logic          pophead_req;
    logic          push_do;
    logic          pophead_do;
    logic          poptail_do;
    logic          clear_do;
    logic [TASK_W-1:0] task_out_next;

    // Steal scan decode.
    logic          scan_end;
    logic [QW-1:0] scan_q;
    logic          scan_hit;

    always_comb
    begin
        thr_ok   = 32'(thr_reg) < THREADS;
        q        = QW'(thr_reg);
        task_nz  = task_reg != TASK_W'(NO_TASK);
        task_ok  = task_nz && (32'(task_reg) < TASKS);
        cur_nz   = cur_reg != TASK_W'(NO_TASK);
        dec      = (mode_reg inside {MODE_ACT_KEEP, MODE_ACT_PUSH, MODE_ACT_ONE})
                   && task_ok && (cnt_rdata != '0);
        fired    = dec && (cnt_rdata == CNT_W'(1));
        q_full   = fill_reg[q] >= FW'(QUEUE_DEPTH);
        q_empty  = fill_reg[q] == '0;
        head_dec = (head_reg[q] == '0) ? PW'(QUEUE_DEPTH - 1) : head_reg[q] - 1'b1;

        push_req = (mode_reg == MODE_PUSH)
                   || (mode_reg == MODE_ACT_KEEP && fired && cur_nz)
                   || (mode_reg == MODE_ACT_PUSH && fired);
        pophead_req = (mode_reg == MODE_POP_HEAD)
                   || (mode_reg == MODE_ACT_ONE && !fired)
                   || (mode_reg == MODE_GET_READY && !cur_nz);
        push_do    = cmd.act && push_req && thr_ok && task_nz && !q_full;
        pophead_do = cmd.act && pophead_req && thr_ok && !q_empty;
        poptail_do = cmd.act && (mode_reg == MODE_POP_TAIL) && thr_ok && !q_empty;
        clear_do   = cmd.act && (mode_reg == MODE_CLEAR) && thr_ok;

        scan_end = (32'(scan_idx_reg) >= 32'(active_threads_reg))
                   || (32'(scan_idx_reg) >= THREADS);
        scan_q   = scan_idx_reg[QW-1:0];
        scan_hit = !scan_end && (32'(scan_idx_reg) != 32'(thr_reg))
                   && (fill_reg[scan_q] != '0);
    end

    // Status toward the controller.
    always_comb
    begin
        st.clr_last  = clr_idx_reg == TIDX_W'(TASKS - 1);
        st.req_valid = req.valid;
        st.is_steal  = mode_reg == MODE_STEAL;
        st.scan_stop = scan_end || scan_hit;
        st.out_free  = !out_valid_reg || rsp.ready;
    end

    // Activation count memory: clearing pass, set count, decrement.
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = TIDX_W'(task_reg);
        cnt_wdata = cnt_in_reg;
        if (cmd.clr_step)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_idx_reg;
            cnt_wdata = '0;
        end
        else if (cmd.cnt_rd)
        begin
            cnt_we = (mode_reg == MODE_SET_COUNT) && (32'(task_reg) < TASKS);
        end
        else if (cmd.act)
        begin
            cnt_we    = dec;
            cnt_wdata = cnt_rdata - 1'b1;
        end
    end

    wsts_ram #(.WIDTH(CNT_W), .DEPTH(TASKS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cmd.cnt_rd),
        .raddr (TIDX_W'(task_reg)),
        .rdata (cnt_rdata)
    );

    // Task store ports.
    always_comb
    begin
        st_we    = push_do;
        st_waddr = {q, head_reg[q]};
        st_re    = pophead_do || poptail_do || (cmd.scan && scan_hit);
        if (cmd.scan)
        begin
            st_raddr = {scan_q, tail_reg[scan_q]};
        end
        else if (poptail_do)
        begin
            st_raddr = {q, tail_reg[q]};
        end
        else
        begin
            st_raddr = {q, head_dec};
        end
    end

    wsts_ram #(.WIDTH(TASK_W), .DEPTH(STORE_DEPTH)) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (task_reg),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_threads_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            active_threads_reg <= cfg_wdata;
        end
    end

    // Item capture on an accepted request beat.
    always_ff @(posedge clk)
    begin
        if (cmd.idle && req.valid)
        begin
            mode_reg   <= req.mode;
            thr_reg    <= req.thread;
            task_reg   <= req.task_req;
            cnt_in_reg <= req.count;
            cur_reg    <= req.current_task;
        end
    end

    // Clearing pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // Queue pointer updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREADS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else if (cmd.scan)
        begin
            if (scan_hit)
            begin
                tail_reg[scan_q] <= (tail_reg[scan_q] == PW'(QUEUE_DEPTH - 1)) ?
                                    '0 : tail_reg[scan_q] + 1'b1;
                fill_reg[scan_q] <= fill_reg[scan_q] - 1'b1;
            end
        end
        else if (clear_do)
        begin
            head_reg[q] <= '0;
            tail_reg[q] <= '0;
            fill_reg[q] <= '0;
        end
        else if (push_do)
        begin
            head_reg[q] <= (head_reg[q] == PW'(QUEUE_DEPTH - 1)) ?
                           '0 : head_reg[q] + 1'b1;
            fill_reg[q] <= fill_reg[q] + 1'b1;
        end
        else if (pophead_do)
        begin
            head_reg[q] <= head_dec;
            fill_reg[q] <= fill_reg[q] - 1'b1;
        end
        else if (poptail_do)
        begin
            tail_reg[q] <= (tail_reg[q] == PW'(QUEUE_DEPTH - 1)) ?
                           '0 : tail_reg[q] + 1'b1;
            fill_reg[q] <= fill_reg[q] - 1'b1;
        end
    end

    // Steal scan counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.act)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan && !scan_end)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    // Result staging: either a value held here or the store's read data.
    always_ff @(posedge clk)
    begin
        if (cmd.act)
        begin
            ovf_reg <= push_req && thr_ok && task_nz && q_full;
            res_reg <= cur_reg;
            src_reg <= 1'b0;
            if (pophead_req || mode_reg == MODE_POP_TAIL)
            begin
                if (pophead_do || poptail_do)
                begin
                    src_reg <= 1'b1;
                end
                else
                begin
                    res_reg <= TASK_W'(NO_TASK);
                end
            end
            if ((mode_reg == MODE_ACT_KEEP && fired && !cur_nz)
                || (mode_reg == MODE_ACT_ONE && fired))
            begin
                res_reg <= task_reg;
            end
        end
        else if (cmd.scan)
        begin
            res_reg <= TASK_W'(NO_TASK);
            src_reg <= scan_hit;
        end
    end

    assign task_out_next = src_reg ? st_rdata : res_reg;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            task_out_reg   <= task_out_next;
            none_found_reg <= task_out_next == TASK_W'(NO_TASK);
            overflow_reg   <= ovf_reg;
        end
    end

    assign req.ready      = cmd.idle;
    assign rsp.valid      = out_valid_reg;
    assign rsp.task_out   = task_out_reg;
    assign rsp.none_found = none_found_reg;
    assign rsp.overflow   = overflow_reg;

`ifndef SYNTH
    // No queue of the item's thread ever holds more than its depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.act |-> (fill_reg[q] <= FW'(QUEUE_DEPTH)))
        else $error("queue fill above depth");

    // A response beat only appears after a result hand-off.
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("response valid without hand-off");

    // A push never writes the store while the store is read.
    a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> !st_re)
        else $error("store written and read in one cycle");
`endif
endmodule

@@ rtl/work_stealing_task_scheduler_unit.sv @@
// ============================================================================
// work_stealing_task_scheduler_unit
// Dependency-driven task scheduler with one double-ended queue per thread
// and an activation count per task.
//
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    mode, thread, task_req, count, current_task
// rsp       out  valid/ready    task_out, none_found, overflow
// cfg       in   cfg_we only    cfg_wdata = active_threads
//
// An item holds the block through intake, count read, queue operation and
// hand-off; its result is written to the output register at hand-off. A
// steal adds a scan step that visits the queues in turn until one has a task.
// The count memory is read in the count read step and written back in the queue step.
// After reset a clearing pass zeroes all TASKS (1024) count entries;
// req is not ready during it. A stalled result waits in the output register
// and holds the next item in its final step until rsp takes the beat.
// ============================================================================
module work_stealing_task_scheduler_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [wsts_pkg::CFG_W-1:0] cfg_wdata,
    wsts_req_if.sink                   req,
    wsts_rsp_if.source                 rsp
);
    import wsts_pkg::*;

    wsts_cmd_t    cmd;
    wsts_status_t st;

    // Sequencing.
    wsts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // Storage and arithmetic.
    wsts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .req       (req),
        .rsp       (rsp)
    );
endmodule
